// File: rtl/tpe_pkg.sv
// Shared types and constants of the thermal palette equaliser.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package tpe_pkg;

    localparam int LW     = 14;              // level width
    localparam int NW     = LW + 1;          // occupied-level count width
    localparam int DW     = NW + LW;         // gap divisor width
    localparam int AW     = 2;               // config index width
    localparam logic [LW-1:0] MAXV = 14'd16383;

    localparam logic [AW-1:0] REG_CLIP_LOW    = 2'd0;
    localparam logic [AW-1:0] REG_CLIP_HIGH   = 2'd1;
    localparam logic [AW-1:0] REG_LINEAR_MODE = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_READ  = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef struct packed {
        logic          req_type;
        logic [LW-1:0] pixel_value;
        logic          last_pixel;
        logic [LW-1:0] map_index;
    } in_t;

    typedef struct packed {
        logic          result_kind;
        logic [LW-1:0] frame_min;
        logic [LW-1:0] frame_max;
        logic [LW-1:0] mapped_level;
    } out_t;

endpackage
`default_nettype wire

// File: rtl/tpe_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tpe_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module tpe_div (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [tpe_pkg::LW-1:0]  dividend,
    input  wire logic [tpe_pkg::DW-1:0]  divisor,
    output logic                         done,
    output logic [tpe_pkg::LW-1:0]       quot,
    output logic [tpe_pkg::DW-1:0]       rem
);
    localparam int CW = $clog2(tpe_pkg::LW + 1);

    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [tpe_pkg::LW-1:0]   q_reg, q_next;
    logic [tpe_pkg::DW-1:0]   r_reg, r_next;
    logic [tpe_pkg::DW-1:0]   d_reg, d_next;
    logic [tpe_pkg::DW:0]     trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[tpe_pkg::LW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(tpe_pkg::LW);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            q_next = {q_reg[tpe_pkg::LW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                trial     = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            r_next   = trial[tpe_pkg::DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule
`default_nettype wire

// File: rtl/thermal_palette_equalizer.sv
// Top level of the thermal palette equaliser: level stores, sequencer, output register.
// Depends on tpe_pkg and tpe_div.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block sweeps both 16384-entry level stores to zero, one entry a cycle,
// and takes no item until the sweep ends. A pixel item reads the level store, then marks
// its level in it. A read item passes the read and emit states, plus any wait on the
// output register. The last pixel of a frame starts the map build: one division of MAXV
// by the occupied-level count (top level left out in step mode, always counted in linear
// mode; no division if that count is zero), then a walk that reads each level in turn. In
// linear mode each occupied level takes one more step, and each gap between occupied levels
// adds two products and a division on the shared divider, plus one write per level in the
// gap. The summary item is given when the walk ends.
module thermal_palette_equalizer (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire tpe_pkg::in_t            in_item,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output tpe_pkg::out_t                out_item,
    input  wire logic                    cfg_we,
    input  wire logic [tpe_pkg::AW-1:0]  cfg_addr,
    input  wire logic [tpe_pkg::LW-1:0]  cfg_wdata
);
    localparam int LW = tpe_pkg::LW;
    localparam int NW = tpe_pkg::NW;
    localparam int DW = tpe_pkg::DW;
    localparam int DEPTH = 1 << LW;

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_PIX    = 4'd2;
    localparam logic [3:0] ST_RD     = 4'd3;
    localparam logic [3:0] ST_EMIT   = 4'd4;
    localparam logic [3:0] ST_BSTART = 4'd5;
    localparam logic [3:0] ST_BDIV   = 4'd6;
    localparam logic [3:0] ST_S_RD   = 4'd7;
    localparam logic [3:0] ST_S_USE  = 4'd8;
    localparam logic [3:0] ST_L_RD   = 4'd9;
    localparam logic [3:0] ST_L_USE  = 4'd10;
    localparam logic [3:0] ST_L_MUL1 = 4'd11;
    localparam logic [3:0] ST_L_MUL2 = 4'd12;
    localparam logic [3:0] ST_L_DIV  = 4'd13;
    localparam logic [3:0] ST_L_GAP  = 4'd14;
    localparam logic [3:0] ST_L_TOP  = 4'd15;

    // level stores
    logic          seen_mem [DEPTH];
    logic [LW-1:0] map_mem  [DEPTH];
    logic          seen_we, seen_wdata, seen_rdata;
    logic [LW-1:0] seen_waddr, seen_raddr;
    logic          map_we, map_re;
    logic [LW-1:0] map_waddr, map_wdata, map_raddr, map_rdata;

    // configuration
    logic [LW-1:0] clip_low_reg, clip_high_reg;
    logic          linear_reg;

    // control
    logic [3:0]    state_reg, state_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] start_reg, start_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic          last_reg, last_next;
    logic          kind_reg, kind_next;
    logic          out_valid_reg, out_valid_next;
    tpe_pkg::out_t out_reg, out_next;

    // frame statistics
    logic [LW-1:0] run_min_reg, run_min_next;
    logic [LW-1:0] run_max_reg, run_max_next;
    logic [NW-1:0] count_reg, count_next;
    logic          top_seen_reg, top_seen_next;

    // build arithmetic
    logic [NW-1:0] n_reg, n_next;
    logic          nz_reg, nz_next;
    logic [LW-1:0] q0_reg, q0_next;
    logic [NW-1:0] r0_reg, r0_next;
    logic [LW-1:0] acc_q_reg, acc_q_next;
    logic [NW-1:0] acc_r_reg, acc_r_next;
    logic [DW-1:0] mul_reg, mul_next;
    logic [DW-1:0] dd_reg, dd_next;
    logic [LW-1:0] q1_reg, q1_next;
    logic [DW-1:0] r1_reg, r1_next;
    logic [LW-1:0] gq_reg, gq_next;
    logic [DW-1:0] gr_reg, gr_next;

    // shared divider and multiplier
    logic          div_start, div_done;
    logic [DW-1:0] div_divisor, div_rem;
    logic [LW-1:0] div_quot;
    logic [NW-1:0] mul_a;
    logic [LW-1:0] mul_b;

    // derived values
    logic [LW-1:0] v_lo, v_clip, gap_d;
    logic [NW:0]   adv_rsum;
    logic [LW-1:0] adv_q;
    logic [NW-1:0] adv_r;
    logic [DW:0]   gap_rsum;
    logic          accept;

    tpe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tpe_pkg::MAXV),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign v_lo   = (in_item.pixel_value < clip_low_reg) ? clip_low_reg : in_item.pixel_value;
    assign v_clip = (v_lo > clip_high_reg) ? clip_high_reg : v_lo;
    assign gap_d  = idx_reg - start_reg;

    // step the running quotient of k*MAXV/n by one occupied level
    always_comb
    begin
        adv_rsum = {1'b0, acc_r_reg} + {1'b0, r0_reg};
        adv_q    = acc_q_reg + q0_reg;
        adv_r    = adv_rsum[NW-1:0];
        if (adv_rsum >= {1'b0, n_reg})
        begin
            adv_r = NW'(adv_rsum - {1'b0, n_reg});
            adv_q = adv_q + 1'b1;
        end
        gap_rsum = {1'b0, gr_reg} + {1'b0, r1_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        start_next     = start_reg;
        lvl_next       = lvl_reg;
        last_next      = last_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        count_next     = count_reg;
        top_seen_next  = top_seen_reg;
        n_next         = n_reg;
        nz_next        = nz_reg;
        q0_next        = q0_reg;
        r0_next        = r0_reg;
        acc_q_next     = acc_q_reg;
        acc_r_next     = acc_r_reg;
        mul_next       = mul_reg;
        dd_next        = dd_reg;
        q1_next        = q1_reg;
        r1_next        = r1_reg;
        gq_next        = gq_reg;
        gr_next        = gr_reg;
        seen_we        = 1'b0;
        seen_waddr     = idx_reg;
        seen_wdata     = 1'b0;
        seen_raddr     = (state_reg == ST_IDLE) ? v_clip : idx_reg;
        map_we         = 1'b0;
        map_waddr      = idx_reg;
        map_wdata      = '0;
        map_re         = 1'b0;
        map_raddr      = in_item.map_index;
        div_start      = 1'b0;
        div_divisor    = {{(DW-NW){1'b0}}, n_reg};
        mul_a          = n_reg;
        mul_b          = gap_d;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                seen_we = 1'b1;
                map_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == tpe_pkg::MAXV)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.req_type == tpe_pkg::REQ_READ)
                    begin
                        map_re     = 1'b1;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        if (in_item.pixel_value < run_min_reg)
                            run_min_next = in_item.pixel_value;
                        if (v_lo > run_max_reg)
                            run_max_next = v_lo;
                        lvl_next   = v_clip;
                        last_next  = in_item.last_pixel;
                        state_next = ST_PIX;
                    end
                end
            end
            ST_PIX:
            begin
                if (!seen_rdata)
                begin
                    seen_we    = 1'b1;
                    seen_waddr = lvl_reg;
                    seen_wdata = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (lvl_reg == tpe_pkg::MAXV)
                        top_seen_next = 1'b1;
                end
                state_next = last_reg ? ST_BSTART : ST_IDLE;
            end
            ST_RD:
            begin
                kind_next  = tpe_pkg::KIND_READ;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.result_kind = kind_reg;
                    if (kind_reg == tpe_pkg::KIND_READ)
                    begin
                        out_next.frame_min    = '0;
                        out_next.frame_max    = '0;
                        out_next.mapped_level = map_rdata;
                    end
                    else
                    begin
                        out_next.frame_min    = run_min_reg;
                        out_next.frame_max    = run_max_reg;
                        out_next.mapped_level = '0;
                        run_min_next          = tpe_pkg::MAXV;
                        run_max_next          = '0;
                        count_next            = '0;
                        top_seen_next         = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_BSTART:
            begin
                if (linear_reg)
                    n_next = count_reg + NW'(!top_seen_reg);
                else
                    n_next = count_reg - NW'(top_seen_reg);
                nz_next    = (n_next != '0);
                acc_q_next = '0;
                acc_r_next = '0;
                idx_next   = '0;
                start_next = '0;
                kind_next  = tpe_pkg::KIND_SUMMARY;
                q0_next    = '0;
                r0_next    = '0;
                div_divisor = {{(DW-NW){1'b0}}, n_next};
                if (n_next != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_BDIV;
                end
                else
                    state_next = ST_S_RD;
            end
            ST_BDIV:
            begin
                if (div_done)
                begin
                    q0_next    = div_quot;
                    r0_next    = div_rem[NW-1:0];
                    state_next = linear_reg ? ST_L_RD : ST_S_RD;
                end
            end
            ST_S_RD:
                state_next = ST_S_USE;
            ST_S_USE:
            begin
                map_we    = 1'b1;
                map_wdata = acc_q_reg;
                seen_we   = 1'b1;
                if (seen_rdata && nz_reg)
                begin
                    acc_q_next = adv_q;
                    acc_r_next = adv_r;
                end
                idx_next = idx_reg + 1'b1;
                state_next = (idx_reg == tpe_pkg::MAXV) ? ST_EMIT : ST_S_RD;
            end
            ST_L_RD:
                state_next = ST_L_USE;
            ST_L_USE:
            begin
                seen_we = 1'b1;
                if (seen_rdata || idx_reg == tpe_pkg::MAXV)
                    state_next = (gap_d == '0) ? ST_L_TOP : ST_L_MUL1;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_L_RD;
                end
            end
            ST_L_MUL1:
            begin
                // gap divisor n*d
                mul_next   = DW'(mul_a) * DW'(mul_b);
                state_next = ST_L_MUL2;
            end
            ST_L_MUL2:
            begin
                // remainder of the gap base, scaled by d
                mul_a       = acc_r_reg;
                dd_next     = mul_reg;
                div_divisor = mul_reg;
                div_start   = 1'b1;
                mul_next    = DW'(mul_a) * DW'(mul_b);
                state_next  = ST_L_DIV;
            end
            ST_L_DIV:
            begin
                if (div_done)
                begin
                    q1_next    = div_quot;
                    r1_next    = div_rem;
                    gq_next    = acc_q_reg;
                    gr_next    = mul_reg;
                    j_next     = start_reg;
                    state_next = ST_L_GAP;
                end
            end
            ST_L_GAP:
            begin
                map_we    = 1'b1;
                map_waddr = j_reg;
                map_wdata = gq_reg;
                gq_next   = gq_reg + q1_reg;
                gr_next   = gap_rsum[DW-1:0];
                if (gap_rsum >= {1'b0, dd_reg})
                begin
                    gr_next = DW'(gap_rsum - {1'b0, dd_reg});
                    gq_next = gq_reg + q1_reg + 1'b1;
                end
                j_next = j_reg + 1'b1;
                if (j_reg == idx_reg - 1'b1)
                    state_next = ST_L_TOP;
            end
            ST_L_TOP:
            begin
                map_we     = 1'b1;
                map_wdata  = adv_q;
                acc_q_next = adv_q;
                acc_r_next = adv_r;
                start_next = idx_reg + 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == tpe_pkg::MAXV) ? ST_EMIT : ST_L_RD;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            run_min_reg   <= tpe_pkg::MAXV;
            run_max_reg   <= '0;
            count_reg     <= '0;
            top_seen_reg  <= 1'b0;
            clip_low_reg  <= '0;
            clip_high_reg <= tpe_pkg::MAXV;
            linear_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            count_reg     <= count_next;
            top_seen_reg  <= top_seen_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    tpe_pkg::REG_CLIP_LOW:    clip_low_reg  <= cfg_wdata;
                    tpe_pkg::REG_CLIP_HIGH:   clip_high_reg <= cfg_wdata;
                    tpe_pkg::REG_LINEAR_MODE: linear_reg    <= cfg_wdata[0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        start_reg <= start_next;
        lvl_reg   <= lvl_next;
        last_reg  <= last_next;
        kind_reg  <= kind_next;
        out_reg   <= out_next;
        n_reg     <= n_next;
        nz_reg    <= nz_next;
        q0_reg    <= q0_next;
        r0_reg    <= r0_next;
        acc_q_reg <= acc_q_next;
        acc_r_reg <= acc_r_next;
        mul_reg   <= mul_next;
        dd_reg    <= dd_next;
        q1_reg    <= q1_next;
        r1_reg    <= r1_next;
        gq_reg    <= gq_next;
        gr_reg    <= gr_next;
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
            seen_mem[seen_waddr] <= seen_wdata;
        seen_rdata <= seen_mem[seen_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        if (map_re)
            map_rdata <= map_mem[map_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/tpe_checker.sv
// Port-level checks of the thermal palette equaliser, bound to the top level.
// Depends on tpe_pkg and thermal_palette_equalizer.
`timescale 1ns / 1ps
`default_nettype none
module tpe_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire tpe_pkg::out_t out_item
);
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    a_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("stalled result item changed");

    a_read_zeros: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.result_kind == tpe_pkg::KIND_READ
            |-> out_item.frame_min == '0 && out_item.frame_max == '0)
        else $error("read result carries frame statistics");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.result_kind == tpe_pkg::KIND_SUMMARY
            |-> out_item.mapped_level == '0)
        else $error("frame summary carries a mapped level");
endmodule

bind thermal_palette_equalizer tpe_checker u_tpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
`default_nettype wire
